@@ rtl/mfb_pkg.sv @@
// Shared types and constants for the monochrome framebuffer rasterizer.
// Holds the item structs, operation codes and register map.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package mfb_pkg;

	// Default canvas size in pixels.
	localparam int DEF_CANVAS_WIDTH  = 128;
	localparam int DEF_CANVAS_HEIGHT = 64;

	// Operation codes of a command item.
	localparam logic [1:0] OP_LINE   = 2'd0;
	localparam logic [1:0] OP_CIRCLE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Configuration port geometry and register indexes.
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] REG_CLIP_LEFT   = 3'd2;
	localparam logic [2:0] REG_CLIP_TOP    = 3'd3;
	localparam logic [2:0] REG_CLIP_RIGHT  = 3'd4;
	localparam logic [2:0] REG_CLIP_BOTTOM = 3'd5;

	// Register reset values.
	localparam logic [7:0] CLIP_RIGHT_RST  = 8'd128;
	localparam logic [6:0] CLIP_BOTTOM_RST = 7'd64;

	// Fill bytes for the clear operation.
	localparam logic [7:0] FILL_ONES  = 8'hFF;
	localparam logic [7:0] FILL_ZEROS = 8'h00;

	// Command item.
	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [14:0]        radius;
		logic               pen_on;
		logic [9:0]         byte_index;
	} cmd_t;

	// Result item.
	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] done_operation;
	} rsp_t;

endpackage

@@ rtl/mfb_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Width and depth are parameters; no dependencies.
`timescale 1ns / 1ps

module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/mono_framebuffer_line_circle_raster.sv @@
// Sequence: a line sets up (LSET, LERR), then steps, plots and writes each pixel (a clipped
// pixel skips the write); a circle plots each of its 8 mirrored points per step, then updates y and x;
// a clear sweeps all STORE_BYTES bytes; a read passes RD and RDW, plus any wait on the result side.
// Throughput: one item at a time; pixel rate is bound by the read-modify-write of the frame RAM.
// Reset: a clearing pass writes zero to all STORE_BYTES bytes, during which cmd_stall stays
// high; configuration registers return to their reset values at once.
`timescale 1ns / 1ps

module mono_framebuffer_line_circle_raster
	import mfb_pkg::*;
#(
	parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
	parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	localparam int PAGES       = (CANVAS_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = CANVAS_WIDTH * PAGES;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam logic [AW-1:0]      LAST_BYTE = AW'(STORE_BYTES - 1);
	localparam logic signed [18:0] CANVAS_W  = 19'(CANVAS_WIDTH);
	localparam logic signed [18:0] CANVAS_H  = 19'(CANVAS_HEIGHT);

	// Sequencer states.
	typedef enum logic [13:0] {
		ST_INIT   = 14'h0001,
		ST_IDLE   = 14'h0002,
		ST_LSET   = 14'h0004,
		ST_LERR   = 14'h0008,
		ST_LSTEP  = 14'h0010,
		ST_CPOINT = 14'h0020,
		ST_CUPDY  = 14'h0040,
		ST_CUPDX  = 14'h0080,
		ST_PLOT   = 14'h0100,
		ST_PWR    = 14'h0200,
		ST_FILL   = 14'h0400,
		ST_RD     = 14'h0800,
		ST_RDW    = 14'h1000,
		ST_FIN    = 14'h2000
	} state_t;

	state_t state_q;
	state_t ret_state;

	// Configuration registers.
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [7:0]         clip_left_q;
	logic [6:0]         clip_top_q;
	logic [7:0]         clip_right_q;
	logic [6:0]         clip_bottom_q;
	logic [2:0]         cfg_idx;
	logic               cfg_wr;

	// Item and walker registers.
	logic [1:0]         op_q;
	logic               pen_q;
	logic [9:0]         bi_q;
	logic signed [15:0] lx_q;
	logic signed [15:0] ly_q;
	logic signed [15:0] ex_q;
	logic signed [15:0] ey_q;
	logic signed [17:0] dx_q;
	logic signed [17:0] dy_q;
	logic               sx_neg_q;
	logic               sy_neg_q;
	logic signed [18:0] err_q;
	logic signed [16:0] ccx_q;
	logic signed [16:0] ccy_q;
	logic [2:0]         oct_q;
	logic               last_q;
	logic signed [17:0] pt_x_q;
	logic signed [17:0] pt_y_q;
	logic [AW-1:0]      pix_addr_q;
	logic [7:0]         pix_mask_q;
	logic [AW-1:0]      fill_q;
	logic [7:0]         rd_data_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// Line setup and step terms.
	logic signed [16:0] dxd;
	logic signed [16:0] dyd;
	logic signed [17:0] dx_abs;
	logic signed [17:0] dy_abs;
	logic signed [19:0] e2;
	logic               step_x;
	logic               step_y;

	// Circle point selection and step terms.
	logic signed [16:0] oa;
	logic signed [16:0] ob;
	logic               ox_pos;
	logic               oy_pos;
	logic signed [16:0] x_next;

	// Pixel unit terms.
	logic signed [18:0] ax;
	logic signed [18:0] ay;
	logic               pix_ok;
	logic [AW-1:0]      pix_addr;
	logic [7:0]         pix_mask;

	// Read index range check.
	logic [AW+9:0]      bi_ext;
	logic               bi_in_range;

	// RAM ports.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [7:0]         ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [7:0]         ram_rdata;

	// Configuration port: always ready, written on the access cycle.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[CFG_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= CLIP_RIGHT_RST;
			clip_bottom_q <= CLIP_BOTTOM_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ORIGIN_X:    origin_x_q    <= pwdata[15:0];
				REG_ORIGIN_Y:    origin_y_q    <= pwdata[15:0];
				REG_CLIP_LEFT:   clip_left_q   <= pwdata[7:0];
				REG_CLIP_TOP:    clip_top_q    <= pwdata[6:0];
				REG_CLIP_RIGHT:  clip_right_q  <= pwdata[7:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_idx)
			REG_ORIGIN_X:    prdata = CFG_DW'(unsigned'(origin_x_q));
			REG_ORIGIN_Y:    prdata = CFG_DW'(unsigned'(origin_y_q));
			REG_CLIP_LEFT:   prdata = CFG_DW'(clip_left_q);
			REG_CLIP_TOP:    prdata = CFG_DW'(clip_top_q);
			REG_CLIP_RIGHT:  prdata = CFG_DW'(clip_right_q);
			REG_CLIP_BOTTOM: prdata = CFG_DW'(clip_bottom_q);
			default:         prdata = '0;
		endcase
	end

	// Line setup: absolute deltas with the sign convention of the error term.
	assign dxd    = 17'(ex_q) - 17'(lx_q);
	assign dyd    = 17'(ey_q) - 17'(ly_q);
	assign dx_abs = (dxd < 0) ? -18'(dxd) : 18'(dxd);
	assign dy_abs = (dyd < 0) ? -18'(dyd) : 18'(dyd);

	// Line step decisions from twice the error.
	assign e2     = 20'(err_q) <<< 1;
	assign step_x = e2 >= 20'(dy_q);
	assign step_y = e2 <= 20'(dx_q);

	// Circle: which coordinate and which signs the current mirrored point uses.
	always_comb begin
		case (oct_q)
			3'd0, 3'd3, 3'd4, 3'd7: begin
				oa = ccx_q;
				ob = ccy_q;
			end
			default: begin
				oa = ccy_q;
				ob = ccx_q;
			end
		endcase
	end
	assign ox_pos = (oct_q == 3'd0) || (oct_q == 3'd1) || (oct_q == 3'd6) || (oct_q == 3'd7);
	assign oy_pos = !oct_q[2];
	assign x_next = (err_q > 0) ? ccx_q - 17'sd1 : ccx_q;

	// Pixel unit: origin offset, canvas and clip tests, byte address and bit mask.
	assign ax = 19'(pt_x_q) + 19'(origin_x_q);
	assign ay = 19'(pt_y_q) + 19'(origin_y_q);
	assign pix_ok = (ax >= 0) && (ax < CANVAS_W) && (ay >= 0) && (ay < CANVAS_H)
		&& (ax >= signed'(19'(clip_left_q))) && (ax < signed'(19'(clip_right_q)))
		&& (ay >= signed'(19'(clip_top_q))) && (ay < signed'(19'(clip_bottom_q)));
	assign pix_addr = AW'(ax) + AW'(AW'(ay >>> 3) * AW'(CANVAS_WIDTH));
	assign pix_mask = 8'(1) << ay[2:0];

	// Read index check against the store size.
	assign bi_ext      = (AW + 10)'(bi_q);
	assign bi_in_range = bi_ext < (AW + 10)'(STORE_BYTES);

	// Where the sequencer resumes after one pixel is done.
	always_comb begin
		if (op_q == OP_LINE) begin
			ret_state = last_q ? ST_FIN : ST_LSTEP;
		end else if (oct_q == 3'd7) begin
			ret_state = ST_CUPDY;
		end else begin
			ret_state = ST_CPOINT;
		end
	end

	// RAM port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_q;
		ram_wdata = FILL_ZEROS;
		ram_raddr = pix_addr;
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = pen_q ? FILL_ONES : FILL_ZEROS;
			end
			ST_PWR: begin
				ram_we    = 1'b1;
				ram_waddr = pix_addr_q;
				ram_wdata = pen_q ? (ram_rdata | pix_mask_q) : (ram_rdata & ~pix_mask_q);
			end
			ST_RD: begin
				ram_raddr = bi_ext[AW-1:0];
			end
			default: ;
		endcase
	end

	mfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			fill_q  <= '0;
			oct_q   <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == LAST_BYTE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						fill_q <= '0;
						oct_q  <= '0;
						case (cmd.operation)
							OP_LINE:   state_q <= ST_LSET;
							OP_CIRCLE: state_q <= ST_CPOINT;
							OP_CLEAR:  state_q <= ST_FILL;
							default:   state_q <= ST_RD;
						endcase
					end
				end
				ST_LSET:   state_q <= ST_LERR;
				ST_LERR:   state_q <= ST_LSTEP;
				ST_LSTEP:  state_q <= ST_PLOT;
				ST_CPOINT: state_q <= ST_PLOT;
				ST_CUPDY:  state_q <= ST_CUPDX;
				ST_CUPDX:  state_q <= (x_next >= ccy_q) ? ST_CPOINT : ST_FIN;
				ST_PLOT: begin
					if (pix_ok) begin
						state_q <= ST_PWR;
					end else begin
						state_q <= ret_state;
						oct_q   <= oct_q + 3'd1;
					end
				end
				ST_PWR: begin
					state_q <= ret_state;
					oct_q   <= oct_q + 3'd1;
				end
				ST_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == LAST_BYTE) begin
						state_q <= ST_FIN;
					end
				end
				ST_RD:  state_q <= ST_RDW;
				ST_RDW: state_q <= ST_FIN;
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walker datapath: item load, line error walk, circle midpoint walk, pixel staging and read capture.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q      <= cmd.operation;
				pen_q     <= cmd.pen_on;
				bi_q      <= cmd.byte_index;
				lx_q      <= cmd.start_x;
				ly_q      <= cmd.start_y;
				ex_q      <= cmd.end_x;
				ey_q      <= cmd.end_y;
				ccx_q     <= 17'(cmd.radius);
				ccy_q     <= '0;
				err_q     <= '0;
				rd_data_q <= '0;
			end
			ST_LSET: begin
				dx_q     <= dx_abs;
				dy_q     <= -dy_abs;
				sx_neg_q <= !(lx_q < ex_q);
				sy_neg_q <= !(ly_q < ey_q);
			end
			ST_LERR: begin
				err_q <= 19'(dx_q) + 19'(dy_q);
			end
			ST_LSTEP: begin
				pt_x_q <= 18'(lx_q);
				pt_y_q <= 18'(ly_q);
				last_q <= (lx_q == ex_q) && (ly_q == ey_q);
				err_q  <= err_q + (step_x ? 19'(dy_q) : 19'sd0)
					+ (step_y ? 19'(dx_q) : 19'sd0);
				if (step_x) begin
					lx_q <= sx_neg_q ? lx_q - 16'sd1 : lx_q + 16'sd1;
				end
				if (step_y) begin
					ly_q <= sy_neg_q ? ly_q - 16'sd1 : ly_q + 16'sd1;
				end
			end
			ST_CPOINT: begin
				pt_x_q <= ox_pos ? 18'(lx_q) + 18'(oa) : 18'(lx_q) - 18'(oa);
				pt_y_q <= oy_pos ? 18'(ly_q) + 18'(ob) : 18'(ly_q) - 18'(ob);
			end
			ST_CUPDY: begin
				if (err_q <= 0) begin
					ccy_q <= ccy_q + 17'sd1;
					err_q <= err_q + (19'(ccy_q) <<< 1) + 19'sd3;
				end
			end
			ST_CUPDX: begin
				if (err_q > 0) begin
					ccx_q <= x_next;
					err_q <= err_q - ((19'(ccx_q) <<< 1) - 19'sd1);
				end
			end
			ST_PLOT: begin
				pix_addr_q <= pix_addr;
				pix_mask_q <= pix_mask;
			end
			ST_RDW: begin
				rd_data_q <= bi_in_range ? ram_rdata : 8'd0;
			end
			default: ;
		endcase
	end

	// Result output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.read_data      <= rd_data_q;
			rsp_q.done_operation <= op_q;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only the read operation returns nonzero data.
	a_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.done_operation != OP_READ) |-> rsp.read_data == 8'd0)
		else $error("nonzero read data on a non-read result");

	// A taken result is not repeated unless a new one is loaded.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && (state_q != ST_FIN) |=> !rsp_valid)
		else $error("result item repeated");

	// The frame RAM is written only by the fill sweeps and the pixel write step.
	a_ram_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_INIT) || (state_q == ST_FILL) || (state_q == ST_PWR))
		else $error("frame RAM written outside a write state");

	// An accepted command always starts work.
	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> state_q != ST_IDLE)
		else $error("accepted command was dropped");

endmodule
